>>> hdl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// Contiguous pool allocator package
// Pool geometry, field widths and operation codes shared by the allocator
// and its channel interfaces.
// ----------------------------------------------------------------------------
package cpa_pkg;

   localparam int POOL_SIZE = 64;
   localparam int ADDR_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int LEN_W     = $clog2(POOL_SIZE + 1);

   localparam int OP_W    = 2;
   localparam int NAME_W  = 8;
   localparam int SIZE_W  = 7;
   localparam int FIT_W   = 2;
   localparam int START_W = 6;

   // Width wide enough to compare a run length with a request size.
   localparam int CMP_W = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;

   localparam logic [NAME_W-1:0] MARKER_RESET = NAME_W'(46);

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPACT = 2'd2;

   localparam logic [FIT_W-1:0] FIT_FIRST   = 2'd0;
   localparam logic [FIT_W-1:0] FIT_BEST    = 2'd1;
   localparam logic [FIT_W-1:0] FIT_WORST   = 2'd2;
   localparam logic [FIT_W-1:0] FIT_INVALID = 2'd3;

endpackage

>>> hdl/cpa_if.sv
// ----------------------------------------------------------------------------
// Contiguous pool allocator channels
// Valid/ready channels for requests, responses and the marker register.
// ----------------------------------------------------------------------------
interface cpa_req_if;
   logic                        valid;
   logic                        ready;
   logic [cpa_pkg::OP_W-1:0]    operation;
   logic [cpa_pkg::NAME_W-1:0]  owner_name;
   logic [cpa_pkg::SIZE_W-1:0]  request_size;
   logic [cpa_pkg::FIT_W-1:0]   fit_policy;

   modport source (output valid, operation, owner_name, request_size, fit_policy,
                   input ready);
   modport sink   (input valid, operation, owner_name, request_size, fit_policy,
                   output ready);
endinterface

interface cpa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        status;
   logic [cpa_pkg::START_W-1:0] block_start;

   modport source (output valid, status, block_start, input ready);
   modport sink   (input valid, status, block_start, output ready);
endinterface

interface cpa_csr_if;
   logic                        valid;
   logic                        ready;
   logic [cpa_pkg::NAME_W-1:0]  free_marker;

   modport source (output valid, free_marker, input ready);
   modport sink   (input valid, free_marker, output ready);
endinterface

>>> hdl/contiguous_pool_allocator.sv
// ----------------------------------------------------------------------------
// Contiguous pool allocator
// First, best and worst fit allocation, free by owner and compaction over a
// pool of byte cells, driven by a small sequencer around one pool memory.
// ----------------------------------------------------------------------------
// The pool memory has a single read port and a single write port, and every
// operation walks it one cell per cycle. Allocate scans the whole pool, decides
// on a run and then stamps request_size cells with the owner name; free scans
// the pool once, and compact scans it once and then refills any free cells
// left at the end of the pool with the marker.
// A refused allocate (invalid policy or zero size) or an unused operation
// answers without a scan; an allocate that finds no fitting run answers
// after the scan. The request channel is ready only between operations, but
// a finished response may wait in the output register while the next
// request is taken. No clearing pass follows reset: per-cell valid bits make
// unwritten cells read as the reset marker.
// ----------------------------------------------------------------------------
module contiguous_pool_allocator (
   input  logic      clock,
   input  logic      reset,
   cpa_req_if.sink   req_ch,
   cpa_rsp_if.source rsp_ch,
   cpa_csr_if.sink   csr_ch
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_SCAN    = 8'b0000_0010,
      ST_CLOSE   = 8'b0000_0100,
      ST_STAMP   = 8'b0000_1000,
      ST_PURGE   = 8'b0001_0000,
      ST_SQUEEZE = 8'b0010_0000,
      ST_FILL    = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   localparam logic [cpa_pkg::LEN_W-1:0] POOL_END  = cpa_pkg::LEN_W'(cpa_pkg::POOL_SIZE);
   localparam logic [cpa_pkg::LEN_W-1:0] POOL_LAST =
      cpa_pkg::LEN_W'(cpa_pkg::POOL_SIZE - 1);

   state_type state_ff, state_in;

   // Read pipeline over the pool.
   logic [cpa_pkg::LEN_W-1:0]   iss_ff, iss_in;
   logic                        pend_ff, pend_in;
   logic [cpa_pkg::ADDR_W-1:0]  pend_idx_ff, pend_idx_in;

   // Captured request.
   logic [cpa_pkg::NAME_W-1:0]  name_ff, name_in;
   logic [cpa_pkg::SIZE_W-1:0]  size_ff, size_in;
   logic [cpa_pkg::FIT_W-1:0]   policy_ff, policy_in;

   // Run tracking for allocate.
   logic [cpa_pkg::ADDR_W-1:0]  run_start_ff, run_start_in;
   logic [cpa_pkg::LEN_W-1:0]   run_len_ff, run_len_in;
   logic                        found_ff, found_in;
   logic [cpa_pkg::ADDR_W-1:0]  chosen_start_ff, chosen_start_in;
   logic [cpa_pkg::LEN_W-1:0]   chosen_len_ff, chosen_len_in;

   // Write pointer for stamping, compaction and refill.
   logic [cpa_pkg::LEN_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [cpa_pkg::SIZE_W-1:0]  left_ff, left_in;

   logic                        res_status_ff, res_status_in;
   logic [cpa_pkg::START_W-1:0] res_start_ff, res_start_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_status_ff, rsp_status_in;
   logic [cpa_pkg::START_W-1:0] rsp_start_ff, rsp_start_in;

   logic [cpa_pkg::NAME_W-1:0]  marker_ff, marker_in;

   // Pool memory and its per-cell valid bits.
   logic [cpa_pkg::NAME_W-1:0]  pool_mem [cpa_pkg::POOL_SIZE];
   logic [cpa_pkg::POOL_SIZE-1:0] cell_vld_ff;
   logic [cpa_pkg::NAME_W-1:0]  rd_data_ff;
   logic                        rd_vld_ff;

   logic                        rd_en;
   logic [cpa_pkg::ADDR_W-1:0]  rd_addr;
   logic                        wr_en;
   logic [cpa_pkg::ADDR_W-1:0]  wr_addr;
   logic [cpa_pkg::NAME_W-1:0]  wr_data;

   logic [cpa_pkg::NAME_W-1:0]  cur_cell;
   logic                        cell_free;
   logic                        req_xfer;
   logic                        scanning;
   logic                        scan_last;
   logic                        ev_en;
   logic                        len_ok;
   logic                        better;
   logic                        fit_take;
   logic [cpa_pkg::ADDR_W-1:0]  start_pick;
   logic [cpa_pkg::ADDR_W+cpa_pkg::START_W-1:0] start_wide;

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.block_start = rsp_start_ff;

   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign cur_cell  = rd_vld_ff ? rd_data_ff : cpa_pkg::MARKER_RESET;
   assign cell_free = (cur_cell == marker_ff);

   assign scanning  = (state_ff == ST_SCAN) || (state_ff == ST_PURGE) ||
                      (state_ff == ST_SQUEEZE);
   assign rd_en     = scanning && (iss_ff != POOL_END);
   assign rd_addr   = iss_ff[cpa_pkg::ADDR_W-1:0];
   // The last cell is in the read register once every address has been issued.
   assign scan_last = (iss_ff == POOL_END) && pend_ff;

   // A run closes at an occupied cell or after the last cell of the pool.
   assign ev_en  = ((state_ff == ST_SCAN) && pend_ff && !cell_free) ||
                   (state_ff == ST_CLOSE);
   assign len_ok = cpa_pkg::CMP_W'(run_len_ff) >= cpa_pkg::CMP_W'(size_ff);
   assign better = !found_ff ||
                   ((policy_ff == cpa_pkg::FIT_BEST)  && (run_len_ff < chosen_len_ff)) ||
                   ((policy_ff == cpa_pkg::FIT_WORST) && (run_len_ff > chosen_len_ff));
   assign fit_take   = ev_en && len_ok && better;
   assign start_pick = fit_take ? run_start_ff : chosen_start_ff;
   assign start_wide = (cpa_pkg::ADDR_W + cpa_pkg::START_W)'(start_pick);

   always_comb begin
      state_in        = state_ff;
      iss_in          = iss_ff;
      pend_in         = pend_ff;
      pend_idx_in     = pend_idx_ff;
      name_in         = name_ff;
      size_in         = size_ff;
      policy_in       = policy_ff;
      run_start_in    = run_start_ff;
      run_len_in      = run_len_ff;
      found_in        = found_ff;
      chosen_start_in = chosen_start_ff;
      chosen_len_in   = chosen_len_ff;
      wr_ptr_in       = wr_ptr_ff;
      left_in         = left_ff;
      res_status_in   = res_status_ff;
      res_start_in    = res_start_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_start_in    = rsp_start_ff;
      marker_in       = marker_ff;
      wr_en           = 1'b0;
      wr_addr         = pend_idx_ff;
      wr_data         = marker_ff;

      if (csr_ch.valid && csr_ch.ready) begin
         marker_in = csr_ch.free_marker;
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (scanning) begin
         pend_in     = rd_en;
         pend_idx_in = rd_addr;
         iss_in      = iss_ff + cpa_pkg::LEN_W'(rd_en);
      end

      if (fit_take) begin
         found_in        = 1'b1;
         chosen_start_in = run_start_ff;
         chosen_len_in   = run_len_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               name_in       = req_ch.owner_name;
               size_in       = req_ch.request_size;
               policy_in     = req_ch.fit_policy;
               iss_in        = '0;
               pend_in       = 1'b0;
               run_len_in    = '0;
               found_in      = 1'b0;
               wr_ptr_in     = '0;
               res_status_in = 1'b0;
               res_start_in  = '0;
               case (req_ch.operation)
                  cpa_pkg::OP_ALLOC: begin
                     if ((req_ch.fit_policy == cpa_pkg::FIT_INVALID) ||
                         (req_ch.request_size == '0)) begin
                        res_status_in = 1'b1;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  cpa_pkg::OP_FREE:    state_in = ST_PURGE;
                  cpa_pkg::OP_COMPACT: state_in = ST_SQUEEZE;
                  default:             state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (pend_ff) begin
               if (cell_free) begin
                  if (run_len_ff == '0) begin
                     run_start_in = pend_idx_ff;
                  end
                  run_len_in = run_len_ff + cpa_pkg::LEN_W'(1);
               end else begin
                  run_len_in = '0;
               end
            end
            if (scan_last) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            if (found_ff || fit_take) begin
               wr_ptr_in    = cpa_pkg::LEN_W'(start_pick);
               left_in      = size_ff;
               res_start_in = start_wide[cpa_pkg::START_W-1:0];
               state_in     = ST_STAMP;
            end else begin
               res_status_in = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_STAMP: begin
            wr_en     = 1'b1;
            wr_addr   = wr_ptr_ff[cpa_pkg::ADDR_W-1:0];
            wr_data   = name_ff;
            wr_ptr_in = wr_ptr_ff + cpa_pkg::LEN_W'(1);
            left_in   = left_ff - cpa_pkg::SIZE_W'(1);
            if (left_ff == cpa_pkg::SIZE_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_PURGE: begin
            if (pend_ff && (cur_cell == name_ff)) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff;
               wr_data = marker_ff;
            end
            if (scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_SQUEEZE: begin
            // Writes trail the reads, so a moved cell never lands on one not yet read.
            if (pend_ff && !cell_free) begin
               wr_en     = 1'b1;
               wr_addr   = wr_ptr_ff[cpa_pkg::ADDR_W-1:0];
               wr_data   = cur_cell;
               wr_ptr_in = wr_ptr_ff + cpa_pkg::LEN_W'(1);
            end
            if (scan_last) begin
               state_in = (wr_ptr_in == POOL_END) ? ST_DONE : ST_FILL;
            end
         end
         ST_FILL: begin
            wr_en     = 1'b1;
            wr_addr   = wr_ptr_ff[cpa_pkg::ADDR_W-1:0];
            wr_data   = marker_ff;
            wr_ptr_in = wr_ptr_ff + cpa_pkg::LEN_W'(1);
            if (wr_ptr_ff == POOL_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         iss_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         marker_ff    <= cpa_pkg::MARKER_RESET;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         iss_ff       <= iss_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         marker_ff    <= marker_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff     <= pend_idx_in;
      name_ff         <= name_in;
      size_ff         <= size_in;
      policy_ff       <= policy_in;
      run_start_ff    <= run_start_in;
      run_len_ff      <= run_len_in;
      chosen_start_ff <= chosen_start_in;
      chosen_len_ff   <= chosen_len_in;
      wr_ptr_ff       <= wr_ptr_in;
      left_ff         <= left_in;
      res_status_ff   <= res_status_in;
      res_start_ff    <= res_start_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_start_ff    <= rsp_start_in;
   end

   // Pool memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pool_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= pool_mem[rd_addr];
         rd_vld_ff  <= cell_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff <= '0;
      end else if (wr_en) begin
         cell_vld_ff[wr_addr] <= 1'b1;
      end
   end

`ifndef SYNTHESIS
   // Stamping never runs past the end of the pool.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STAMP) |->
         ((cpa_pkg::CMP_W + 1)'(wr_ptr_ff) + (cpa_pkg::CMP_W + 1)'(left_ff) <=
          (cpa_pkg::CMP_W + 1)'(cpa_pkg::POOL_SIZE)))
      else $error("allocation stamp runs past the end of the pool");

   // Compaction writes only at or below the cell being examined.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SQUEEZE) && wr_en) |->
         (wr_ptr_ff <= cpa_pkg::LEN_W'(pend_idx_ff)))
      else $error("compaction write overtakes the read pointer");

   // A response appears only when an operation finishes.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside the done step");

   // A failed allocate reports block start zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_start_ff == '0))
      else $error("failed allocate reports a nonzero start");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous pool allocator testbench
// Drives allocate, free and compact requests through the request channel,
// predicts every response from a private copy of the pool and checks each
// response transfer in order. The free marker is changed between phases
// while the allocator is idle, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import cpa_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 340;
   localparam int LONG_HOLD   = 600;
   localparam int IDLE_LIMIT  = 4000;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [NAME_W-1:0] name;
      logic [SIZE_W-1:0] size;
      logic [FIT_W-1:0]  fit;
   } pool_req_type;

   typedef struct packed {
      logic               status;
      logic [START_W-1:0] start;
   } pool_rsp_type;

   class alloc_scoreboard;
      logic [NAME_W-1:0] cells [POOL_SIZE];
      logic [NAME_W-1:0] marker;
      pool_rsp_type      pending [$];
      int                errors;

      function new();
         marker = MARKER_RESET;
         foreach (cells[k]) cells[k] = MARKER_RESET;
         errors = 0;
      endfunction

      function void set_marker(logic [NAME_W-1:0] value);
         marker = value;
      endfunction

      function bit drained();
         return pending.size() == 0;
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("tb: %s", what);
      endfunction

      // Applies one accepted request to the private pool and queues the answer.
      function void note_request(pool_req_type r);
         int           i, run_beg, pick_start, pick_len, dst;
         bit           found;
         pool_rsp_type answer;
         answer = '0;
         case (r.op)
            OP_ALLOC: begin
               found = 1'b0;
               pick_start = 0;
               pick_len = 0;
               i = 0;
               if (r.fit != FIT_INVALID && r.size != 0) begin
                  while (i < POOL_SIZE) begin
                     if (cells[i] != marker) begin
                        i++;
                     end else begin
                        run_beg = i;
                        while (i < POOL_SIZE && cells[i] == marker) i++;
                        if (i - run_beg >= int'(r.size)) begin
                           if (!found) begin
                              found = 1'b1;
                              pick_start = run_beg;
                              pick_len = i - run_beg;
                              if (r.fit == FIT_FIRST) break;
                           end else if ((r.fit == FIT_BEST && i - run_beg < pick_len) ||
                                        (r.fit == FIT_WORST && i - run_beg > pick_len)) begin
                              pick_start = run_beg;
                              pick_len = i - run_beg;
                           end
                        end
                     end
                  end
               end
               if (found) begin
                  for (int k = 0; k < int'(r.size); k++) cells[pick_start + k] = r.name;
                  answer.start = START_W'(pick_start);
               end else begin
                  answer.status = 1'b1;
               end
            end
            OP_FREE: begin
               foreach (cells[k]) if (cells[k] == r.name) cells[k] = marker;
            end
            OP_COMPACT: begin
               dst = 0;
               for (int k = 0; k < POOL_SIZE; k++) begin
                  if (cells[k] != marker) begin
                     cells[dst] = cells[k];
                     dst++;
                  end
               end
               while (dst < POOL_SIZE) begin
                  cells[dst] = marker;
                  dst++;
               end
            end
            default: ;
         endcase
         pending.push_back(answer);
      endfunction

      function void check_response(pool_rsp_type got);
         pool_rsp_type want;
         if (pending.size() == 0) begin
            flag($sformatf("response with nothing outstanding: status %0d start %0d",
                           got.status, got.start));
         end else begin
            want = pending.pop_front();
            if (want.status !== got.status || want.start !== got.start)
               flag($sformatf("mismatch: status exp %0d got %0d, start exp %0d got %0d",
                              want.status, got.status, want.start, got.start));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   cpa_req_if req_ch ();
   cpa_rsp_if rsp_ch ();
   cpa_csr_if csr_ch ();

   contiguous_pool_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   alloc_scoreboard sb = new();

   logic [NAME_W-1:0] owners [8];
   int hold_left = 0;
   int results_seen = 0;
   int idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_gap(int short_max, int long_max);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, short_max);
      return $urandom_range(short_max + 1, long_max);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic push_request(input logic [OP_W-1:0] op, input logic [NAME_W-1:0] name,
                               input logic [SIZE_W-1:0] size, input logic [FIT_W-1:0] fit);
      int           gap;
      pool_req_type r;
      gap = idle_gap(6, 150);
      r.op = op;
      r.name = name;
      r.size = size;
      r.fit = fit;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.owner_name <= name;
      req_ch.request_size <= size;
      req_ch.fit_policy <= fit;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (!sb.drained()) @(negedge clock);
   endtask

   task automatic write_marker(input logic [NAME_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.free_marker <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.set_marker(value);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Random traffic over a small set of owners so that frees hit live blocks.
   // Two owners are retired at the start of every phase and replaced.
   task automatic run_phase(input int count, input logic [NAME_W-1:0] old_marker);
      int                roll, sub;
      logic [OP_W-1:0]   op;
      logic [NAME_W-1:0] name;
      logic [SIZE_W-1:0] size;
      logic [FIT_W-1:0]  fit;
      for (int k = 0; k < 2; k++) begin
         push_request(OP_FREE, owners[k], SIZE_W'($urandom_range(0, 127)), FIT_FIRST);
         owners[k] = NAME_W'($urandom_range(0, 255));
      end
      repeat (count) begin
         roll = $urandom_range(0, 99);
         sub = $urandom_range(0, 99);
         op = OP_ALLOC;
         fit = FIT_W'($urandom_range(0, 2));
         name = owners[$urandom_range(0, 7)];
         if (sub < 70) size = SIZE_W'($urandom_range(1, 8));
         else if (sub < 92) size = SIZE_W'($urandom_range(9, 24));
         else size = SIZE_W'($urandom_range(25, 64));
         if (roll < 50) begin
            sub = $urandom_range(0, 99);
            if (sub >= 95) name = sb.marker;
            else if (sub >= 85) name = NAME_W'($urandom_range(0, 255));
         end else if (roll < 80) begin
            op = OP_FREE;
            sub = $urandom_range(0, 99);
            if (sub >= 90) name = old_marker;
            else if (sub >= 80) name = NAME_W'($urandom_range(0, 255));
         end else if (roll < 88) begin
            op = OP_COMPACT;
         end else begin
            // Requests the allocator must refuse or ignore.
            case ($urandom_range(0, 3))
               0: fit = FIT_INVALID;
               1: begin
                  op = OP_UNUSED;
                  fit = FIT_W'($urandom_range(0, 3));
                  size = SIZE_W'($urandom_range(0, 127));
                  name = NAME_W'($urandom_range(0, 255));
               end
               2: size = 7'd0;
               default: size = SIZE_W'($urandom_range(POOL_SIZE + 1, 127));
            endcase
         end
         push_request(op, name, size, fit);
      end
   endtask

   always @(posedge clock) begin
      pool_rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status = rsp_ch.status;
         got.start = rsp_ch.block_start;
         sb.check_response(got);
         results_seen++;
         // A long hold-off lets the allocator fill its output and stall requests.
         if (results_seen == 300 || results_seen == 1200) hold_left = LONG_HOLD;
         else hold_left = idle_gap(3, 40);
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      logic [NAME_W-1:0] old_m, next_m;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_ALLOC;
      req_ch.owner_name = '0;
      req_ch.request_size = '0;
      req_ch.fit_policy = FIT_FIRST;
      csr_ch.valid = 1'b0;
      csr_ch.free_marker = '0;
      reset = 1'b1;
      foreach (owners[k]) owners[k] = NAME_W'($urandom_range(0, 255));
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: whole pool, refusals, fit choices, marker as owner, compaction.
      push_request(OP_ALLOC, 8'h5A, 7'd64, FIT_FIRST);
      push_request(OP_FREE, 8'h5A, 7'd0, FIT_FIRST);
      push_request(OP_ALLOC, 8'h41, 7'd4, FIT_FIRST);
      push_request(OP_ALLOC, 8'h42, 7'd64, FIT_WORST);
      push_request(OP_ALLOC, 8'h43, 7'd10, FIT_BEST);
      push_request(OP_ALLOC, 8'h00, 7'd3, FIT_FIRST);
      push_request(OP_ALLOC, 8'hFF, 7'd5, FIT_FIRST);
      push_request(OP_FREE, 8'h43, 7'd0, FIT_FIRST);
      push_request(OP_ALLOC, 8'h44, 7'd2, FIT_BEST);
      push_request(OP_ALLOC, 8'h45, 7'd2, FIT_WORST);
      push_request(OP_ALLOC, 8'h46, 7'd1, FIT_INVALID);
      push_request(OP_ALLOC, 8'h47, 7'd0, FIT_FIRST);
      push_request(OP_ALLOC, 8'h48, 7'd127, FIT_FIRST);
      push_request(OP_ALLOC, MARKER_RESET, 7'd3, FIT_FIRST);
      push_request(OP_FREE, MARKER_RESET, 7'd0, FIT_FIRST);
      push_request(OP_UNUSED, 8'hA5, 7'h55, FIT_INVALID);
      push_request(OP_COMPACT, 8'h00, 7'd0, FIT_FIRST);
      push_request(OP_ALLOC, 8'h49, 7'd7, FIT_WORST);
      push_request(OP_FREE, 8'h00, 7'd0, FIT_FIRST);
      push_request(OP_FREE, 8'hFF, 7'd0, FIT_FIRST);
      push_request(OP_ALLOC, 8'h4B, 7'd3, FIT_BEST);
      push_request(OP_COMPACT, 8'h00, 7'd0, FIT_FIRST);
      push_request(OP_ALLOC, 8'h4C, 7'd64, FIT_FIRST);

      run_phase(PHASE_ITEMS, MARKER_RESET);
      for (int p = 0; p < 4; p++) begin
         old_m = sb.marker;
         case (p)
            0: next_m = 8'h00;
            1: next_m = 8'hFF;
            2: next_m = owners[$urandom_range(2, 7)];
            default: next_m = MARKER_RESET;
         endcase
         settle();
         write_marker(next_m);
         run_phase(PHASE_ITEMS, old_m);
      end
      settle();

      // Give a stray extra response time to show up.
      repeat (2 * POOL_SIZE + 10) @(posedge clock);
      if (!sb.drained()) sb.flag("responses still outstanding at the end");
      if (sb.errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
